// File: rtl/mpfd_pkg.sv
// Package for the page-organized monochrome framebuffer draw core.
// Holds operation codes, controller states, command and status structs.
// No dependencies.
package mpfd_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;
    localparam int PAGE_ROWS        = 8;
    localparam int GLYPH_COLS       = 5;
    localparam int GLYPH_ROWS       = 7;

    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_GLYPH = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_step;
        logic rmw_read;
        logic rmw_write;
        logic step;
        logic read_item;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       sweep_last;
        logic       slot_active;
        logic       slot_last;
        logic       out_free;
    } status_t;

endpackage

// File: rtl/mono_page_framebuffer_draw_core.sv
// Top level of the page-organized monochrome framebuffer draw core.
// Instantiates mpfd_ctrl and mpfd_datapath; depends on mpfd_pkg.
//
// This block keeps a PANEL_WIDTH x PANEL_HEIGHT monochrome frame in a single
// memory of PANEL_WIDTH bytes per page of eight rows, where pixel (x, y) is
// bit y mod 8 of byte x + (y / 8) * PANEL_WIDTH. Each input transfer carries
// one operation and produces exactly one output transfer: clear the whole
// frame, set or clear one pixel (off-panel pixels are flagged in ignored),
// draw a 5x7 glyph whose five column bitmaps arrive with the item (codes
// outside 32 to 126 are flagged and draw nothing; glyph pixels wrap modulo
// 256 and are clipped silently), or read back one stored byte. Work is done
// one item at a time by a controller driving a single-port frame memory with
// a registered read. An on-panel pixel item does one read-modify-write of
// its byte; an off-panel pixel item writes nothing. A glyph item visits ten
// byte slots (five columns by two pages); each slot that holds visible rows
// gets a read-modify-write and each empty slot is stepped over. A clear item
// sweeps the memory one byte per cycle. After reset the same sweep clears
// all STORE_BYTES bytes (1024 at the default size) with in_stall high before
// the first item is taken. The result sits in an output register, so the
// next item is accepted while an earlier result waits for the consumer.
module mono_page_framebuffer_draw_core
    import mpfd_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  x,
    input  logic [7:0]  y,
    input  logic        pixel_value,
    input  logic [7:0]  char_code,
    input  logic [7:0]  glyph_col0,
    input  logic [7:0]  glyph_col1,
    input  logic [7:0]  glyph_col2,
    input  logic [7:0]  glyph_col3,
    input  logic [7:0]  glyph_col4,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        ignored
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences clear sweeps, byte read-modify-writes and
    // byte reads; it sees only the status summary from the datapath.
    mpfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the frame memory, the captured item, the byte
    // address and mask logic, and the output register.
    mpfd_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .x           (x),
        .y           (y),
        .pixel_value (pixel_value),
        .char_code   (char_code),
        .glyph_col0  (glyph_col0),
        .glyph_col1  (glyph_col1),
        .glyph_col2  (glyph_col2),
        .glyph_col3  (glyph_col3),
        .glyph_col4  (glyph_col4),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .ignored     (ignored)
    );

endmodule

// File: rtl/mpfd_ctrl.sv
// Controller state machine of the framebuffer draw core.
// Depends on mpfd_pkg for the state enum and the command and status structs.
module mpfd_ctrl
    import mpfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.in_mode)
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_PIXEL: state_next = ST_SCAN;
                        MODE_GLYPH: state_next = ST_SCAN;
                        MODE_READ:  state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                priority if (status.slot_active)
                begin
                    state_next = ST_WRITE;
                end
                else if (status.slot_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                state_next = status.slot_last ? ST_FINISH : ST_SCAN;
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.rmw_read = status.slot_active;
                cmd.step     = !status.slot_active && !status.slot_last;
            end
            ST_WRITE:
            begin
                cmd.rmw_write = 1'b1;
                cmd.step      = !status.slot_last;
            end
            ST_READ:
            begin
                cmd.read_item = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/mpfd_datapath.sv
// Datapath of the framebuffer draw core: frame memory, item registers,
// byte address and mask generation, read-modify-write merge, result register.
// Depends on mpfd_pkg for codes, constants and the command and status structs.
module mpfd_datapath
    import mpfd_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  mode,
    input  logic [7:0]  x,
    input  logic [7:0]  y,
    input  logic        pixel_value,
    input  logic [7:0]  char_code,
    input  logic [7:0]  glyph_col0,
    input  logic [7:0]  glyph_col1,
    input  logic [7:0]  glyph_col2,
    input  logic [7:0]  glyph_col3,
    input  logic [7:0]  glyph_col4,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        ignored
);

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(PANEL_WIDTH);
    localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(STORE_BYTES - 1);
    localparam logic [8:0] WIDTH_9  = 9'(PANEL_WIDTH);
    localparam logic [8:0] HEIGHT_9 = 9'(PANEL_HEIGHT);
    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    logic [7:0]        x_reg;
    logic [7:0]        y_reg;
    logic [7:0]        cols_reg [GLYPH_COLS];
    logic [6:0]        row_mask_reg;
    logic [2:0]        ncols_last_reg;
    logic              draw_en_reg;
    logic              ign_reg;
    logic              is_read_reg;
    logic              read_ok_reg;
    logic [9:0]        ridx_reg;
    logic [2:0]        col_reg;
    logic              slot_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic              ignored_reg;

    logic [7:0]        px;
    logic [4:0]        page;
    logic [ADDR_W-1:0] byte_addr;
    logic [15:0]       win_mask;
    logic [15:0]       win_data;
    logic [7:0]        slot_mask;
    logic [7:0]        slot_data;
    logic [7:0]        row_ok;
    logic              col_ok;
    logic [7:0]        eff_mask;
    logic [7:0]        merged;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;
    logic              code_ok;
    logic              pixel_ok;

    // Byte of the current column and page slot. A glyph covers at most two
    // pages; the second slot is the page below, wrapping in 8-bit row space.
    always_comb
    begin
        px        = x_reg + {5'd0, col_reg};
        page      = y_reg[7:3] + {4'd0, slot_reg};
        byte_addr = ADDR_W'(px) + ADDR_W'(page) * WIDTH_A;
        win_mask  = {9'd0, row_mask_reg} << y_reg[2:0];
        win_data  = {9'd0, cols_reg[col_reg][6:0]} << y_reg[2:0];
        slot_mask = slot_reg ? win_mask[15:8] : win_mask[7:0];
        slot_data = slot_reg ? win_data[15:8] : win_data[7:0];
        for (int b = 0; b < PAGE_ROWS; b++)
        begin
            row_ok[b] = ({1'b0, page, 3'(b)} < HEIGHT_9);
        end
        col_ok    = draw_en_reg && (col_reg <= ncols_last_reg) && ({1'b0, px} < WIDTH_9);
        eff_mask  = slot_mask & row_ok & {8{col_ok}};
        merged    = (rdata_reg & ~eff_mask) | (slot_data & eff_mask);
    end

    always_comb
    begin
        code_ok  = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
        pixel_ok = ({1'b0, x} < WIDTH_9) && ({1'b0, y} < HEIGHT_9);
    end

    always_comb
    begin
        mem_we    = cmd.sweep_step || cmd.rmw_write;
        mem_waddr = cmd.sweep_step ? sweep_cnt_reg : byte_addr;
        mem_wdata = cmd.sweep_step ? 8'd0 : merged;
        mem_re    = cmd.rmw_read || cmd.read_item;
        mem_raddr = cmd.read_item ? ADDR_W'(ridx_reg) : byte_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Item payload, captured at the input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= x;
            y_reg    <= y;
            ridx_reg <= read_index;
            if (mode == MODE_PIXEL)
            begin
                cols_reg[0]    <= {8{pixel_value}};
                row_mask_reg   <= 7'h01;
                ncols_last_reg <= 3'd0;
            end
            else
            begin
                cols_reg[0]    <= glyph_col0;
                row_mask_reg   <= 7'h7F;
                ncols_last_reg <= LAST_COL;
            end
            cols_reg[1] <= glyph_col1;
            cols_reg[2] <= glyph_col2;
            cols_reg[3] <= glyph_col3;
            cols_reg[4] <= glyph_col4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_en_reg   <= 1'b0;
            ign_reg       <= 1'b0;
            is_read_reg   <= 1'b0;
            read_ok_reg   <= 1'b0;
            col_reg       <= 3'd0;
            slot_reg      <= 1'b0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                unique case (mode)
                    MODE_PIXEL:
                    begin
                        draw_en_reg <= pixel_ok;
                        ign_reg     <= !pixel_ok;
                    end
                    MODE_GLYPH:
                    begin
                        draw_en_reg <= code_ok;
                        ign_reg     <= !code_ok;
                    end
                    default:
                    begin
                        draw_en_reg <= 1'b0;
                        ign_reg     <= 1'b0;
                    end
                endcase
                is_read_reg   <= (mode == MODE_READ);
                read_ok_reg   <= (32'(read_index) < 32'(STORE_BYTES));
                col_reg       <= 3'd0;
                slot_reg      <= 1'b0;
                sweep_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.step)
                begin
                    if (slot_reg)
                    begin
                        col_reg  <= col_reg + 3'd1;
                        slot_reg <= 1'b0;
                    end
                    else
                    begin
                        slot_reg <= 1'b1;
                    end
                end
                if (cmd.sweep_step)
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Result register; it frees when the consumer takes the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_data_reg <= (is_read_reg && read_ok_reg) ? rdata_reg : 8'd0;
            ignored_reg   <= ign_reg;
        end
    end

    always_comb
    begin
        status.in_mode     = mode;
        status.sweep_last  = (sweep_cnt_reg == SWEEP_END);
        status.slot_active = |eff_mask;
        status.slot_last   = (col_reg == ncols_last_reg) && slot_reg;
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign ignored   = ignored_reg;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for mono_page_framebuffer_draw_core.
// Predicts each result from its own copy of the frame bytes and checks every output transfer.
// Depends on mpfd_pkg and the RTL of the draw core only.
module testbench;
    import mpfd_pkg::*;

    // Frame size at the default panel parameters: 128 columns by 8 pages.
    localparam int STORE_BYTES =
        DEF_PANEL_WIDTH * ((DEF_PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);

    // A clear sweeps the whole memory one byte per cycle, so even the slowest
    // legal run sees a transfer far sooner than this.
    localparam int WATCHDOG_LIMIT = 20000;

    // Cycles of quiet after the last result, to catch stray output transfers.
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [1:0]      mode;
        logic [7:0]      x;
        logic [7:0]      y;
        logic            pixel_value;
        logic [7:0]      char_code;
        logic [4:0][7:0] cols;
        logic [9:0]      read_index;
    } draw_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ignored;
    } draw_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [7:0] read_data;
    logic ignored;

    // The payload is driven from one register so that it changes as a whole.
    draw_item_t cur_item = '0;

    // Items waiting to be presented, and results the block still owes us.
    draw_item_t   draw_q[$];
    draw_result_t due_results[$];

    // Our own image of the frame memory.
    logic [7:0] frame_bytes [STORE_BYTES];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_queued = 0;
    int results_seen = 0;
    int fail_count = 0;
    int stuck_cycles = 0;
    bit in_taken = 1'b0;

    // Coverage tallies for the closing summary.
    int mode_count [4] = '{0, 0, 0, 0};
    int flagged_count = 0;
    int nonzero_reads = 0;

    // Byte index of the most recent on-panel drawing, so that many reads land
    // on bytes that actually hold something.
    int recent_index = 0;

    mono_page_framebuffer_draw_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (cur_item.mode),
        .x           (cur_item.x),
        .y           (cur_item.y),
        .pixel_value (cur_item.pixel_value),
        .char_code   (cur_item.char_code),
        .glyph_col0  (cur_item.cols[0]),
        .glyph_col1  (cur_item.cols[1]),
        .glyph_col2  (cur_item.cols[2]),
        .glyph_col3  (cur_item.cols[3]),
        .glyph_col4  (cur_item.cols[4]),
        .read_index  (cur_item.read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .ignored     (ignored)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Writes one pixel into the image. Off-panel pixels leave it alone and
    // report that nothing was written.
    function automatic bit plot_pixel(logic [7:0] px, logic [7:0] py, logic on);
        int idx;
        if (px >= DEF_PANEL_WIDTH || py >= DEF_PANEL_HEIGHT)
            return 1'b0;
        idx = px + (py / PAGE_ROWS) * DEF_PANEL_WIDTH;
        if (idx >= STORE_BYTES)
            return 1'b0;
        frame_bytes[idx][py % PAGE_ROWS] = on;
        return 1'b1;
    endfunction

    // Applies one accepted item to the image and returns the result it owes.
    function automatic draw_result_t predict_item(draw_item_t it);
        draw_result_t res;
        logic [7:0] px;
        logic [7:0] py;
        res = '0;
        case (it.mode)
            MODE_CLEAR:
            begin
                foreach (frame_bytes[i])
                    frame_bytes[i] = '0;
            end
            MODE_PIXEL:
            begin
                res.ignored = !plot_pixel(it.x, it.y, it.pixel_value);
            end
            MODE_GLYPH:
            begin
                if (it.char_code < CODE_FIRST || it.char_code > CODE_LAST)
                begin
                    res.ignored = 1'b1;
                end
                else
                begin
                    // Coordinates wrap at 8 bits before each pixel is clipped,
                    // and row 7 of every column is never touched.
                    for (int c = 0; c < GLYPH_COLS; c++)
                    begin
                        for (int r = 0; r < GLYPH_ROWS; r++)
                        begin
                            px = it.x + 8'(c);
                            py = it.y + 8'(r);
                            void'(plot_pixel(px, py, it.cols[c][r]));
                        end
                    end
                end
            end
            default:
            begin
                if (it.read_index < STORE_BYTES)
                    res.read_data = frame_bytes[it.read_index];
            end
        endcase
        return res;
    endfunction

    function automatic draw_item_t make_item(logic [1:0] m, logic [7:0] px, logic [7:0] py,
                                             logic on, logic [7:0] code,
                                             logic [39:0] cols, logic [9:0] idx);
        draw_item_t it;
        it.mode = m;
        it.x = px;
        it.y = py;
        it.pixel_value = on;
        it.char_code = code;
        it.cols = cols;
        it.read_index = idx;
        return it;
    endfunction

    // Random item. Every field is random first so that unused fields toggle too;
    // the fields that matter are then steered toward the panel, mostly with legal
    // codes, and toward the bytes that were drawn last.
    function automatic draw_item_t random_item();
        draw_item_t it;
        int pick;
        int sel;
        it.mode = 2'($urandom_range(3));
        it.x = 8'($urandom_range(255));
        it.y = 8'($urandom_range(255));
        it.pixel_value = 1'($urandom_range(1));
        it.char_code = 8'($urandom_range(255));
        for (int c = 0; c < GLYPH_COLS; c++)
            it.cols[c] = 8'($urandom_range(255));
        it.read_index = 10'($urandom_range(STORE_BYTES - 1));

        pick = $urandom_range(99);
        sel = $urandom_range(99);
        if (pick == 0)
        begin
            it.mode = MODE_CLEAR;
        end
        else if (pick <= 35)
        begin
            it.mode = MODE_PIXEL;
            if (sel < 85)
            begin
                it.x = 8'($urandom_range(DEF_PANEL_WIDTH - 1));
                it.y = 8'($urandom_range(DEF_PANEL_HEIGHT - 1));
            end
        end
        else if (pick <= 65)
        begin
            it.mode = MODE_GLYPH;
            if ($urandom_range(99) < 85)
                it.char_code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
            // Mostly on the panel, some straddling the right and bottom edges,
            // some wrapping around from the top of the 8-bit coordinate range.
            if (sel < 65)
            begin
                it.x = 8'($urandom_range(DEF_PANEL_WIDTH - 1));
                it.y = 8'($urandom_range(DEF_PANEL_HEIGHT - 1));
            end
            else if (sel < 80)
            begin
                it.x = 8'($urandom_range(DEF_PANEL_WIDTH + 2, DEF_PANEL_WIDTH - 6));
                it.y = 8'($urandom_range(DEF_PANEL_HEIGHT + 2, DEF_PANEL_HEIGHT - 8));
            end
            else if (sel < 92)
            begin
                it.x = 8'($urandom_range(255, 250));
                it.y = 8'($urandom_range(255, 249));
            end
        end
        else
        begin
            it.mode = MODE_READ;
            if (sel < 45)
                it.read_index = 10'(recent_index);
            else if (sel < 60)
                it.read_index = 10'((recent_index + DEF_PANEL_WIDTH) % STORE_BYTES);
        end

        if ((it.mode == MODE_PIXEL || it.mode == MODE_GLYPH)
            && it.x < DEF_PANEL_WIDTH && it.y < DEF_PANEL_HEIGHT)
            recent_index = it.x + (it.y / PAGE_ROWS) * DEF_PANEL_WIDTH;
        return it;
    endfunction

    task automatic queue_item(draw_item_t it);
        draw_q.push_back(it);
        items_queued++;
    endtask

    // Holds the stimulus back until the block has answered every item so far.
    task automatic wait_all_answered();
        do
            @(negedge clk);
        while (results_seen != items_queued);
    endtask

    // Input side: an item is transferred at an edge where valid is high and
    // stall is low. Its result is predicted right there, in acceptance order.
    always @(posedge clk)
    begin
        draw_result_t res;
        in_taken = 1'b0;
        if (rst_n && in_valid && !in_stall)
        begin
            in_taken = 1'b1;
            res = predict_item(cur_item);
            due_results.push_back(res);
            mode_count[cur_item.mode]++;
            if (res.ignored)
                flagged_count++;
            if (cur_item.mode == MODE_READ && res.read_data != 8'd0)
                nonzero_reads++;
        end
    end

    // Driver: works on the falling edge. A presented item holds until it is
    // transferred; after that the next one goes out unless the sender idles.
    // The receiver stall is redrawn every cycle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (draw_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item <= draw_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: every output transfer is checked against the oldest prediction.
    // The watchdog counts cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("output transfer with no result expected: read_data=%0h ignored=%0b",
                       read_data, ignored);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", want.read_data, read_data);
                    fail_count++;
                end
                if (ignored !== want.ignored)
                begin
                    $error("ignored: expected %0b, got %0b", want.ignored, ignored);
                    fail_count++;
                end
            end
        end

        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (frame_bytes[i])
            frame_bytes[i] = '0;

        // Reset once. The block then clears its memory on its own with the
        // input stalled; the driver simply waits out that stall.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sender idles now and then, receiver stalls most cycles.
        send_idle_pct = 28;
        recv_idle_pct = 85;

        // Directed part. The memory starts cleared, so the first reads show zero.
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_READ, 8'hFF, 8'hFF, 1'b1, 8'hFF, '1, 10'd1023));
        // Corner pixels, then pixels just off the right and bottom edges.
        queue_item(make_item(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_PIXEL, 8'd128, 8'd0, 1'b1, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_PIXEL, 8'd0, 8'd64, 1'b1, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_PIXEL, 8'hFF, 8'hFF, 1'b0, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd1023));
        // Clearing a single pixel.
        queue_item(make_item(MODE_PIXEL, 8'd127, 8'd63, 1'b0, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd1023));
        // Codes just outside the printable range and at the field extremes
        // are rejected and draw nothing.
        queue_item(make_item(MODE_GLYPH, 8'd10, 8'd10, 1'b0, 8'd31, '1, 10'd0));
        queue_item(make_item(MODE_GLYPH, 8'd10, 8'd10, 1'b0, 8'd127, '1, 10'd0));
        queue_item(make_item(MODE_GLYPH, 8'd10, 8'd10, 1'b0, 8'd0, '1, 10'd0));
        queue_item(make_item(MODE_GLYPH, 8'd10, 8'd10, 1'b0, 8'd255, '1, 10'd0));
        // Lowest legal code with every bit set: bit 7 of each column must not
        // reach row 7.
        queue_item(make_item(MODE_GLYPH, 8'd0, 8'd0, 1'b0, 8'd32, '1, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd0));
        // Highest legal code near the bottom right: the left three columns fall
        // off the panel, the last two wrap to columns 0 and 1, and rows past
        // the bottom edge are clipped.
        queue_item(make_item(MODE_GLYPH, 8'd253, 8'd60, 1'b0, 8'd126,
                             40'h80_01_7F_AA_55, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd896));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd897));
        // Vertical wrap: the top four rows sit at 252 to 255 and are clipped,
        // the last three land on rows 0 to 2.
        queue_item(make_item(MODE_GLYPH, 8'd5, 8'd252, 1'b0, 8'd65, 40'hFF_7F_F0_0F_FF, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd5));
        // An all-zero glyph writes off pixels over what was drawn before.
        queue_item(make_item(MODE_GLYPH, 8'd0, 8'd0, 1'b0, 8'd126, 40'd0, 10'd0));
        queue_item(make_item(MODE_READ, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd0));
        queue_item(make_item(MODE_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0, 40'd0, 10'd0));

        for (int i = 0; i < 560; i++)
            queue_item(random_item());
        wait_all_answered();

        // Phase two: the roles swap, with a starved block and an eager consumer.
        send_idle_pct = 85;
        recv_idle_pct = 28;
        for (int i = 0; i < 580; i++)
            queue_item(random_item());
        wait_all_answered();

        // Phase three: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 590; i++)
            queue_item(random_item());
        wait_all_answered();

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d transfers: %0d clears, %0d pixels, %0d glyphs, %0d reads.",
                 results_seen, mode_count[MODE_CLEAR], mode_count[MODE_PIXEL],
                 mode_count[MODE_GLYPH], mode_count[MODE_READ]);
        $display("%0d items were flagged as ignored and %0d reads returned nonzero bytes.",
                 flagged_count, nonzero_reads);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
